// ===== rtl/core/hfd_pkg.sv =====
// ----------------------------------------------------------------------------
// hfd_pkg: shared constants for the hex float to double converter
// Field widths and format constants.
// ----------------------------------------------------------------------------
package hfd_pkg;
  localparam int RawW     = 64;
  localparam int CountW   = 4;
  localparam int FracW    = 56;
  localparam int PosW     = 6;
  localparam int SigBits  = 52;
  localparam int ExpBias  = 1023;
  localparam int HexBias  = 64;
  localparam int ExpW     = 11;
  localparam int InDataW  = 72;
  localparam int OutDataW = 64;

  typedef struct packed {
    logic             sign;
    logic [6:0]       hexexp;
    logic [FracW-1:0] frac;
    logic [5:0]       fbits;
    logic             bad;
  } s1_t;

  typedef struct packed {
    logic             sign;
    logic [6:0]       hexexp;
    logic [FracW-1:0] frac;
    logic [5:0]       fbits;
    logic [PosW-1:0]  pos;
    logic             zero;
    logic             bad;
  } s2_t;

  typedef struct packed {
    logic             sign;
    logic [SigBits:0] mant;
    logic signed [11:0] biased;
    logic             zero;
    logic             bad;
  } s3_t;
endpackage

// ===== rtl/core/hex_float_to_ieee_double.sv =====
// ----------------------------------------------------------------------------
// hex_float_to_ieee_double: excess-64 base-16 real to IEEE 754 binary64
// Four-stage pipeline: unpack, leading-one search, normalize and round, pack.
// ----------------------------------------------------------------------------
// Takes one request per cycle when not stalled and delivers its double through
// four register stages (unpack, leading-one search, normalize/round, pack).
// Throughput is one item per clock while the output is not stalled, since
// every stage takes a new item each cycle. All stages move together under
// one enable, so a stall at the output holds every stage and nothing is lost
// or repeated. A byte count outside 2..8 gives zero data with tuser set.
module hex_float_to_ieee_double (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // raw_bytes [63:0], byte_count [67:64], zero fill [71:68]
  input  logic [hfd_pkg::InDataW-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // double_bits [63:0]
  output logic [hfd_pkg::OutDataW-1:0]  m_tdata,
  // bad_length
  output logic                          m_tuser
);
  logic [3:0] vld;
  logic       adv;
  hfd_pkg::s1_t s1, s1_next;
  hfd_pkg::s2_t s2, s2_next;
  hfd_pkg::s3_t s3, s3_next;
  logic [hfd_pkg::OutDataW-1:0] dout, dout_next;
  logic bad_out;

  assign adv      = m_tready || !vld[3];
  assign s_tready = adv;
  assign m_tvalid = vld[3];
  assign m_tdata  = dout;
  assign m_tuser  = bad_out;

  // stage 1: unpack and align fraction to the low bits
  always_comb begin
    logic [63:0] raw;
    logic [3:0]  n;
    logic [63:0] sh;
    raw = s_tdata[63:0];
    n   = s_tdata[67:64];
    s1_next.sign   = raw[63];
    s1_next.hexexp = raw[62:56];
    s1_next.bad    = (n < 4'd2) || (n > 4'd8);
    // 8 * (n - 1) and 8 * (8 - n), taken modulo 64 for legal counts 2..8
    s1_next.fbits  = {n[2:0] - 3'd1, 3'b000};
    sh = {8'd0, raw[55:0]} >> {3'd0 - n[2:0], 3'b000};
    s1_next.frac   = s1_next.bad ? '0 : sh[55:0];
    if (s1_next.bad) s1_next.fbits = 6'd8;
  end

  // stage 2: leading-one position
  always_comb begin
    s2_next.sign   = s1.sign;
    s2_next.hexexp = s1.hexexp;
    s2_next.frac   = s1.frac;
    s2_next.fbits  = s1.fbits;
    s2_next.bad    = s1.bad;
    s2_next.zero   = (s1.frac == '0);
    s2_next.pos    = '0;
    for (int i = 0; i < hfd_pkg::FracW; i++) begin
      if (s1.frac[i]) s2_next.pos = 6'(i);
    end
  end

  // stage 3: normalize to 53 bits, round to nearest even
  always_comb begin
    logic [55:0] f;
    logic [1:0]  sh;
    logic [53:0] m;
    logic [2:0]  rem;
    logic [2:0]  half;
    logic [6:0]  p;
    logic        up;
    f = s2.frac;
    p = {1'b0, s2.pos};
    rem = '0; half = '0; up = 1'b0; sh = '0;
    if (s2.pos > 6'd52) begin
      sh   = 2'(s2.pos - 6'd52);
      m    = 54'(f >> sh);
      rem  = f[2:0] & ((3'd1 << sh) - 3'd1);
      half = 3'd1 << (sh - 2'd1);
      up   = (rem > half) || (rem == half && m[0]);
      m    = m + 54'(up);
      if (m[53]) begin
        m = m >> 1;
        p = p + 7'd1;
      end
    end else begin
      m = 54'(f << (6'd52 - s2.pos));
    end
    s3_next.sign   = s2.sign;
    s3_next.mant   = m[52:0];
    s3_next.biased = 12'(signed'({1'b0, p}) + 12'sd4 * (signed'({5'd0, s2.hexexp})
                     - 12'sd64) - signed'({6'd0, s2.fbits}) + 12'sd1023);
    s3_next.zero   = s2.zero;
    s3_next.bad    = s2.bad;
  end

  // stage 4: pack
  always_comb begin
    if (s3.bad)       dout_next = '0;
    else if (s3.zero) dout_next = {s3.sign, 63'd0};
    else dout_next = {s3.sign, s3.biased[10:0], s3.mant[51:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1      <= s1_next;
      s2      <= s2_next;
      s3      <= s3_next;
      dout    <= dout_next;
      bad_out <= s3.bad;
    end
  end
endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: hex float to IEEE double converter
// Drives excess-64 base-16 reals through the stream input, predicts each
// double with a local rounding model and checks every result in order, with
// random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [hfd_pkg::InDataW-1:0]  s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [hfd_pkg::OutDataW-1:0] m_tdata;
  logic                         m_tuser;

  typedef struct packed {
    logic [63:0] dbl;
    logic        bad;
  } dbl_t;

  dbl_t   dbl_queue[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     idle_on = 1'b1;
  bit     hold_off = 1'b0;
  bit     done = 1'b0;

  always #2 clk = ~clk;

  hex_float_to_ieee_double i_dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  function automatic dbl_t convert_hex(logic [63:0] raw, logic [3:0] n);
    dbl_t        r;
    logic [55:0] frac;
    logic [55:0] mant;
    logic [55:0] rem;
    logic [55:0] half;
    int          fbits;
    int          p;
    int          sh;
    int          e2;
    int          biased;
    r = '0;
    if (n < 2 || n > 8) begin
      r.bad = 1'b1;
      return r;
    end
    fbits = 8 * (n - 1);
    frac = 56'(raw[55:0] >> (64 - 8 * n));
    if (frac == 0) begin
      r.dbl = {raw[63], 63'd0};
      return r;
    end
    e2 = 4 * (int'(raw[62:56]) - 64) - fbits;
    p = 0;
    for (int i = 0; i < 56; i++) if (frac[i]) p = i;
    if (p > 52) begin
      sh = p - 52;
      rem = frac & ((56'd1 << sh) - 1);
      half = 56'd1 << (sh - 1);
      mant = frac >> sh;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == (56'd1 << 53)) begin
        mant = mant >> 1;
        p++;
      end
    end else begin
      mant = frac << (52 - p);
    end
    biased = p + e2 + 1023;
    r.dbl = {raw[63], 11'(biased), mant[51:0]};
    return r;
  endfunction

  task automatic send_real(logic [63:0] raw, logic [3:0] n);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, n, raw};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    dbl_queue.push_back(convert_hex(raw, n));
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (dbl_queue.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts, or a long hold when asked.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off) begin
      m_tready <= 1'b0;
    end else if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      idle_cycles <= $urandom_range(0, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    dbl_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (dbl_queue.size() == 0) begin
        $error("unexpected result data=%h bad=%b", m_tdata, m_tuser);
        errors++;
      end else begin
        want = dbl_queue.pop_front();
        if (m_tdata !== want.dbl) begin
          $error("double_bits expected %h actual %h", want.dbl, m_tdata);
          errors++;
        end
        if (m_tuser !== want.bad) begin
          $error("bad_length expected %b actual %b", want.bad, m_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    int stuck;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off) stuck = 0;
    else if (!done) stuck++;
    if (stuck > 2000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic test_directed;
    send_real(64'h4110_0000_0000_0000, 4'd8);
    send_real(64'hC110_0000_0000_0000, 4'd8);
    send_real(64'h0000_0000_0000_0000, 4'd8);
    send_real(64'h8000_0000_0000_0000, 4'd8);
    send_real(64'h7F00_0000_0000_0000, 4'd2);
    send_real(64'h7FFF_FFFF_FFFF_FFFF, 4'd8);
    send_real(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_real(64'h0010_0000_0000_0000, 4'd8);
    send_real(64'h00FF_FFFF_FFFF_FFFF, 4'd8);
    send_real(64'h0001_0000_0000_0000, 4'd2);
    send_real(64'h41FF_FFFF_FFFF_FFF8, 4'd8);
    send_real(64'h41FF_FFFF_FFFF_FFF7, 4'd8);
    send_real(64'h4110_0000_0000_0008, 4'd8);
    send_real(64'h4110_0000_0000_0018, 4'd8);
    send_real(64'h4110_0000_0000_000C, 4'd8);
    send_real(64'h4110_0000_0000_0004, 4'd8);
    send_real(64'h42AB_CDEF_1234_5678, 4'd5);
    send_real(64'h42AB_CDEF_1234_5678, 4'd7);
    send_real(64'h42AB_CDEF_1234_5678, 4'd0);
    send_real(64'h42AB_CDEF_1234_5678, 4'd1);
    send_real(64'h42AB_CDEF_1234_5678, 4'd9);
    send_real(64'h42AB_CDEF_1234_5678, 4'd15);
    drain();
  endtask

  task automatic test_random(int count);
    logic [63:0] raw;
    logic [3:0]  n;
    for (int i = 0; i < count; i++) begin
      raw = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) n = 4'($urandom_range(0, 15));
      else n = 4'($urandom_range(2, 8));
      case ($urandom_range(0, 7))
        0: raw[55:0] = 56'd0;
        1: raw[55:52] = 4'd0;
        2: raw[2:0] = 3'b100;
        3: raw[55:4] = '1;
        default: ;
      endcase
      send_real(raw, n);
    end
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(40);
    join
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(800);
    drain();
    idle_on = 1'b0;
    test_random(200);
    drain();
    repeat (20) @(posedge clk);
    done = 1'b1;
    if (errors == 0 && dbl_queue.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
